// ----- hdl/rwfb_pkg.sv -----
// Shared types, constants and the drive angle limiter for the register-write
// frame builder. No dependencies.

package rwfb_pkg;

    localparam int MAX_VALUES_DEF  = 24;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] HDR_SYNC0 = 8'hEB;
    localparam logic [7:0] HDR_SYNC1 = 8'h90;
    localparam logic [7:0] OPC_WRITE = 8'h12;

    localparam logic signed [15:0] DRV1_LO  = -16'sd150;
    localparam logic signed [15:0] DRV1_HI  = 16'sd0;
    localparam logic signed [15:0] WRIST_LO = -16'sd200;
    localparam logic signed [15:0] WRIST_HI = 16'sd200;
    localparam logic signed [15:0] WIDE_LO  = 16'sd0;
    localparam logic signed [15:0] WIDE_HI  = 16'sd1000;
    localparam logic signed [15:0] STD_LO   = 16'sd0;
    localparam logic signed [15:0] STD_HI   = 16'sd900;

    // Byte position within the emitted sequence for one queue entry
    typedef enum logic [3:0] {
        STEP_SYNC0,
        STEP_SYNC1,
        STEP_DEV,
        STEP_LEN,
        STEP_OPC,
        STEP_ADDR_LO,
        STEP_ADDR_HI,
        STEP_VAL_LO,
        STEP_VAL_HI,
        STEP_CSUM
    } step_t;

    // One classified value, handed from front to back
    typedef struct packed {
        logic        first;
        logic        last;
        logic [7:0]  dev_addr;
        logic [7:0]  len;
        logic [15:0] addr;
        logic [15:0] data;
    } entry_t;

    function automatic logic signed [15:0] clamp_value(
        input logic [4:0]         drive,
        input logic signed [15:0] v
    );
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        logic signed [15:0] res;
        lo = STD_LO;
        hi = STD_HI;
        if (drive == 5'd1)
        begin
            lo = DRV1_LO;
            hi = DRV1_HI;
        end
        else if (drive >= 5'd2 && drive <= 5'd5)
        begin
            lo = WRIST_LO;
            hi = WRIST_HI;
        end
        else if (drive == 5'd18 || drive == 5'd19 || drive == 5'd23 || drive == 5'd24)
        begin
            lo = WIDE_LO;
            hi = WIDE_HI;
        end
        res = v;
        if (v < lo)
            res = lo;
        else if (v > hi)
            res = hi;
        return res;
    endfunction

endpackage

// ----- hdl/rwfb_fifo.sv -----
// Small flip-flop queue between the frame front end and the byte sequencer.
// Generic width/depth; no package dependency.

module rwfb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_next;
    logic [CNTW-1:0]  count_next;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ----- hdl/rwfb_front.sv -----
// Front end: accepts value beats, tracks frame position, drive id and clamp mode,
// clamps the value in clamp mode and builds one queue entry per beat. Uses rwfb_pkg.

module rwfb_front import rwfb_pkg::*; #(
    parameter int MAX_VALUES = MAX_VALUES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_data,
    input  logic               in_valid,
    input  logic               q_full,
    input  logic [15:0]        reg_address,
    input  logic [4:0]         value_count,
    input  logic [4:0]         first_drive,
    input  logic               clamp_angles,
    input  logic signed [15:0] value,
    output logic               push,
    output entry_t             entry
);
    localparam int CW = $clog2(MAX_VALUES + 1);

    logic [7:0]         dev_addr_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      count_reg;
    logic [4:0]         drive_reg;
    logic               clamp_reg;

    logic               first;
    logic [CW-1:0]      sat_count;
    logic [CW-1:0]      eff_count;
    logic [4:0]         eff_drive;
    logic               eff_clamp;
    logic [CW:0]        idx_inc;
    logic               last;
    logic signed [15:0] data;

    assign push = in_valid && !q_full;
    assign first = (idx_reg == '0);

    always_comb
    begin
        if (value_count == 5'd0)
            sat_count = CW'(1);
        else if (32'(value_count) > MAX_VALUES)
            sat_count = CW'(MAX_VALUES);
        else
            sat_count = CW'(value_count);
    end

    assign eff_count = first ? sat_count : count_reg;
    assign eff_drive = first ? first_drive : drive_reg;
    assign eff_clamp = first ? clamp_angles : clamp_reg;
    assign idx_inc   = {1'b0, idx_reg} + 1'b1;
    assign last      = (idx_inc >= {1'b0, eff_count});
    assign data      = eff_clamp ? clamp_value(eff_drive, value) : value;

    always_comb
    begin
        entry.first    = first;
        entry.last     = last;
        entry.dev_addr = dev_addr_reg;
        entry.len      = 8'((32'(sat_count) << 1) + 32'd3);
        entry.addr     = reg_address;
        entry.data     = data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= 8'd1;
            idx_reg      <= '0;
            count_reg    <= '0;
            drive_reg    <= 5'd1;
            clamp_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                dev_addr_reg <= cfg_data;
            if (push)
            begin
                if (first)
                begin
                    count_reg <= sat_count;
                    clamp_reg <= clamp_angles;
                end
                drive_reg <= eff_drive + 5'd1;
                idx_reg   <= last ? '0 : idx_inc[CW-1:0];
            end
        end
    end

endmodule

// ----- hdl/rwfb_back.sv -----
// Back end: pops queue entries and emits header, value and checksum bytes,
// one per beat, through a registered output stage. Uses rwfb_pkg.

module rwfb_back import rwfb_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  entry_t     q_entry,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] frame_byte,
    output logic       end_of_frame
);
    entry_t     cur_reg;
    logic       cur_valid_reg;
    step_t      step_reg;
    step_t      step_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic       out_valid_reg;
    logic [7:0] byte_reg;
    logic       eof_reg;

    logic       advance;
    logic       emit;
    logic       done;
    logic [7:0] byte_sel;

    assign advance = !out_valid_reg || !out_stall;
    assign emit    = cur_valid_reg && advance;
    assign done    = emit && ((step_reg == STEP_VAL_HI && !cur_reg.last)
                              || step_reg == STEP_CSUM);
    assign pop     = (!cur_valid_reg || done) && !q_empty;

    always_comb
    begin
        byte_sel  = sum_reg;
        step_next = STEP_SYNC0;
        unique case (step_reg)
            STEP_SYNC0:   begin byte_sel = HDR_SYNC0;           step_next = STEP_SYNC1;   end
            STEP_SYNC1:   begin byte_sel = HDR_SYNC1;           step_next = STEP_DEV;     end
            STEP_DEV:     begin byte_sel = cur_reg.dev_addr;    step_next = STEP_LEN;     end
            STEP_LEN:     begin byte_sel = cur_reg.len;         step_next = STEP_OPC;     end
            STEP_OPC:     begin byte_sel = OPC_WRITE;           step_next = STEP_ADDR_LO; end
            STEP_ADDR_LO: begin byte_sel = cur_reg.addr[7:0];   step_next = STEP_ADDR_HI; end
            STEP_ADDR_HI: begin byte_sel = cur_reg.addr[15:8];  step_next = STEP_VAL_LO;  end
            STEP_VAL_LO:  begin byte_sel = cur_reg.data[7:0];   step_next = STEP_VAL_HI;  end
            STEP_VAL_HI:  begin byte_sel = cur_reg.data[15:8];  step_next = STEP_CSUM;    end
            STEP_CSUM:    begin byte_sel = sum_reg;             step_next = STEP_SYNC0;   end
            default:      begin byte_sel = sum_reg;             step_next = STEP_SYNC0;   end
        endcase
    end

    // checksum covers device id through the last value byte
    always_comb
    begin
        case (step_reg) inside
            STEP_SYNC0:            sum_next = '0;
            STEP_SYNC1, STEP_CSUM: sum_next = sum_reg;
            default:               sum_next = sum_reg + byte_sel;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= STEP_SYNC0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
                step_reg      <= q_entry.first ? STEP_SYNC0 : STEP_VAL_LO;
            end
            else if (done)
                cur_valid_reg <= 1'b0;
            else if (emit)
                step_reg <= step_next;
            if (emit)
                sum_reg <= sum_next;
            if (advance)
                out_valid_reg <= cur_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= q_entry;
        if (emit)
        begin
            byte_reg <= byte_sel;
            eof_reg  <= (step_reg == STEP_CSUM);
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_byte   = byte_reg;
    assign end_of_frame = eof_reg;

endmodule

// ----- hdl/register_write_frame_builder_top.sv -----
// Top level of the register-write frame builder: front end, entry queue, byte
// sequencer. Depends on rwfb_pkg, rwfb_front, rwfb_fifo, rwfb_back.
//
//  channel | signals                                    | handshake
//  --------+--------------------------------------------+-------------------
//  cfg     | cfg_data[7:0] (device id)                  | cfg_valid/cfg_ready
//  in      | reg_address, value_count, first_drive,     | in_valid/in_stall
//          | clamp_angles, value                        |
//  out     | frame_byte, end_of_frame                   | out_valid/out_stall
//
// One value beat in yields two bytes out, plus 7 header bytes on the first value
// of a frame and 1 checksum byte on the last; the sequencer emits one byte per
// cycle while an entry is waiting and out_stall is low. The entry queue lets
// values enter while the sequencer is busy; in_stall is raised only when it is
// full. A first byte passes the queue, current-entry and output byte registers.
// Reset is asynchronous, active low; device id resets to 1.

module register_write_frame_builder_top import rwfb_pkg::*; #(
    parameter int MAX_VALUES  = MAX_VALUES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        reg_address,
    input  logic [4:0]         value_count,
    input  logic [4:0]         first_drive,
    input  logic               clamp_angles,
    input  logic signed [15:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         frame_byte,
    output logic               end_of_frame
);
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_empty;
    entry_t wr_entry;
    entry_t rd_entry;
    logic [$bits(entry_t)-1:0] rd_bits;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign rd_entry  = entry_t'(rd_bits);

    rwfb_front #(
        .MAX_VALUES (MAX_VALUES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .q_full       (q_full),
        .reg_address  (reg_address),
        .value_count  (value_count),
        .first_drive  (first_drive),
        .clamp_angles (clamp_angles),
        .value        (value),
        .push         (push),
        .entry        (wr_entry)
    );

    rwfb_fifo #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_entry),
        .pop     (pop),
        .rd_data (rd_bits),
        .full    (q_full),
        .empty   (q_empty)
    );

    rwfb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_entry      (rd_entry),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_byte   (frame_byte),
        .end_of_frame (end_of_frame)
    );

endmodule
